### rtl/core/totp_pkg.sv
// shared types and constants for the time step one-time code generator
// sha-256 round constants, initial hash value and config register indexes
package totp_pkg;

    localparam int CfgDataWidth = 64;
    localparam int CfgIndexWidth = 3;

    localparam logic [CfgIndexWidth-1:0] CFG_KEY_HIGH = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_KEY_LOW = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_SOURCE_ADDRESS = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_STEP_SECONDS = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_START_TIME = 3'd4;

    localparam logic [63:0] KEY_HIGH_RESET = 64'd3472611983179986487;
    localparam logic [63:0] KEY_LOW_RESET = 64'd4051376414998685030;
    localparam logic [15:0] SOURCE_ADDRESS_RESET = 16'd4660;
    localparam logic [15:0] STEP_SECONDS_RESET = 16'd3;
    localparam logic [30:0] START_TIME_RESET = 31'd1747636421;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    typedef logic [31:0] word_t;
    typedef logic [255:0] digest_t;
    typedef logic [511:0] block_t;

    localparam digest_t SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t round_const(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // control from the sequencer into the compression unit
    typedef struct packed {
        logic   start;
        block_t block;
        digest_t chain;
    } sha_req_t;

    typedef struct packed {
        logic    done;
        digest_t digest;
    } sha_rsp_t;

endpackage

### rtl/core/totp_stream_if.sv
// valid/ready channel carrying a payload of parameterized type
// used for the request and result channels of the code generator
interface totp_stream_if #(
    parameter type payload_t = logic [31:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/totp_divider.sv
// signed 32-bit by unsigned 16-bit division, one quotient bit per cycle
// depends on totp_pkg
module totp_divider
    import totp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] mag_reg, mag_next;
    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[15:0], mag_reg[31]};
        if (start)
        begin
            mag_next = dividend[31] ? (~dividend + 32'd1) : dividend;
            rem_next = '0;
            quo_next = '0;
            // zero step length acts as one
            div_next = (divisor == 16'd0) ? 16'd1 : divisor;
            neg_next = dividend[31];
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 32'd1) : quo_reg;
endmodule

### rtl/core/totp_sha_core.sv
// sha-256 compression of one block, one round per cycle
// message schedule held in a 16-word shift register; depends on totp_pkg
module totp_sha_core
    import totp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sha_req_t req,
    output sha_rsp_t rsp
);
    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_FINAL} state_t;

    state_t state_reg;
    logic [5:0] rnd_reg;
    logic [3:0] ld_reg;
    word_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    digest_t chain_reg, dig_reg;
    block_t blk_reg;
    logic done_reg;

    // schedule window as a 16-word shift register; the four taps are read
    // straight from fixed positions of the window
    word_t w_reg [16];
    word_t w_cur, w_new, s0, s1, t1, t2;

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        t1 = h_reg + (rotr(e_reg, 6) ^ rotr(e_reg, 11) ^ rotr(e_reg, 25))
            + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + round_const(rnd_reg) + w_cur;
        t2 = (rotr(a_reg, 2) ^ rotr(a_reg, 13) ^ rotr(a_reg, 22))
            + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            rnd_reg <= '0;
            ld_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= S_LOAD;
                        ld_reg <= '0;
                    end
                end
                S_LOAD:
                begin
                    ld_reg <= ld_reg + 4'd1;
                    if (ld_reg == 4'd15)
                    begin
                        state_reg <= S_ROUND;
                        rnd_reg <= '0;
                    end
                end
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    state_reg <= S_IDLE;
                    done_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    blk_reg <= req.block;
                    chain_reg <= req.chain;
                    {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= req.chain;
                end
            end
            S_LOAD:
            begin
                // shift the block into the window, first word ends at tap zero
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= blk_reg[511:480];
                blk_reg <= {blk_reg[479:0], 32'h0};
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= w_new;
                h_reg <= g_reg;
                g_reg <= f_reg;
                f_reg <= e_reg;
                e_reg <= d_reg + t1;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= a_reg;
                a_reg <= t1 + t2;
            end
            S_FINAL:
            begin
                dig_reg <= {chain_reg[255:224] + a_reg, chain_reg[223:192] + b_reg,
                            chain_reg[191:160] + c_reg, chain_reg[159:128] + d_reg,
                            chain_reg[127:96] + e_reg, chain_reg[95:64] + f_reg,
                            chain_reg[63:32] + g_reg, chain_reg[31:0] + h_reg};
            end
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.digest = dig_reg;
endmodule

### rtl/core/time_step_otp_generator.sv
// channel   dir  payload
// request   in   now_seconds (32)
// result    out  otp_code (31), step_used (32 signed), sequence_used (32)
// each code passes in order through accept, the serial divider (load,
// 32 quotient bits, done), the state memory read and write back, four
// sha-256 compressions (start, load of 16 words, 64 rounds, final, done),
// truncation and the result state. reset clears all control; the result
// register holds while the sink stalls, and the next request waits until
// the result is taken.
// depends on totp_pkg, totp_stream_if, totp_divider, totp_sha_core
module time_step_otp_generator
    import totp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    totp_stream_if.sink   req,
    totp_stream_if.source rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_RD, S_UPD, S_SHA_IK, S_SHA_IM, S_SHA_OK, S_SHA_OM,
        S_TRUNC, S_OUT
    } state_t;

    state_t state_reg;
    logic [63:0] key_high_reg, key_low_reg;
    logic [15:0] src_reg, step_sec_reg;
    logic [30:0] start_reg;
    logic [31:0] now_reg;

    // step/sequence memory, one entry; valid bit gives its zero reset value
    logic [63:0] st_mem [1];
    logic [63:0] st_rd_reg;
    logic        st_valid_reg;

    logic [31:0] step_reg, seq_reg;
    digest_t inner_reg, chain_reg;
    logic [30:0] code_reg;
    logic        div_start, div_done;
    logic [31:0] quotient;
    sha_req_t    sreq;
    sha_rsp_t    srsp;
    logic        sha_go_reg;
    block_t      key_block;
    logic [7:0]  dbyte [32];
    logic [3:0]  off;
    logic [31:0] st_cur_step, st_cur_seq;

    totp_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(now_reg - {1'b0, start_reg}), .divisor(step_sec_reg),
        .done(div_done), .quotient(quotient)
    );

    totp_sha_core u_sha (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

    assign div_start = (state_reg == S_DIV) && sha_go_reg;
    assign key_block = {key_high_reg, key_low_reg, 384'h0};
    assign st_cur_step = st_valid_reg ? st_rd_reg[63:32] : 32'h0;
    assign st_cur_seq = st_valid_reg ? st_rd_reg[31:0] : 32'h0;

    always_comb
    begin
        sreq.start = sha_go_reg && (state_reg != S_DIV);
        sreq.chain = SHA_IV;
        sreq.block = key_block ^ {64{IPAD}};
        case (state_reg)
            S_SHA_IM:
            begin
                sreq.chain = chain_reg;
                sreq.block = {step_reg[7:0], step_reg[15:8], step_reg[23:16],
                              step_reg[31:24], seq_reg[7:0], seq_reg[15:8],
                              seq_reg[23:16], seq_reg[31:24], src_reg[7:0],
                              src_reg[15:8], 8'h80, 360'h0, 64'd592};
            end
            S_SHA_OK: sreq.block = key_block ^ {64{OPAD}};
            S_SHA_OM:
            begin
                sreq.chain = chain_reg;
                sreq.block = {inner_reg, 8'h80, 184'h0, 64'd768};
            end
            default: ;
        endcase
        for (int i = 0; i < 32; i++)
        begin
            dbyte[i] = srsp.digest[255-8*i -: 8];
        end
        off = dbyte[31][3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= KEY_HIGH_RESET;
            key_low_reg <= KEY_LOW_RESET;
            src_reg <= SOURCE_ADDRESS_RESET;
            step_sec_reg <= STEP_SECONDS_RESET;
            start_reg <= START_TIME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW: key_low_reg <= cfg_data;
                CFG_SOURCE_ADDRESS: src_reg <= cfg_data[15:0];
                CFG_STEP_SECONDS: step_sec_reg <= cfg_data[15:0];
                CFG_START_TIME: start_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        st_rd_reg <= st_mem[0];
        if (state_reg == S_UPD)
        begin
            st_mem[0] <= {step_reg, seq_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sha_go_reg <= 1'b0;
            st_valid_reg <= 1'b0;
            rsp.valid <= 1'b0;
        end
        else
        begin
            sha_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        now_reg <= req.data;
                        state_reg <= S_DIV;
                        sha_go_reg <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        step_reg <= quotient;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    // memory read data is valid this cycle
                    if (quotient != st_cur_step)
                    begin
                        seq_reg <= 32'h0;
                    end
                    else
                    begin
                        seq_reg <= st_cur_seq + 32'd1;
                    end
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    st_valid_reg <= 1'b1;
                    sha_go_reg <= 1'b1;
                    state_reg <= S_SHA_IK;
                end
                S_SHA_IK:
                begin
                    if (srsp.done)
                    begin
                        chain_reg <= srsp.digest;
                        sha_go_reg <= 1'b1;
                        state_reg <= S_SHA_IM;
                    end
                end
                S_SHA_IM:
                begin
                    if (srsp.done)
                    begin
                        inner_reg <= srsp.digest;
                        sha_go_reg <= 1'b1;
                        state_reg <= S_SHA_OK;
                    end
                end
                S_SHA_OK:
                begin
                    if (srsp.done)
                    begin
                        chain_reg <= srsp.digest;
                        sha_go_reg <= 1'b1;
                        state_reg <= S_SHA_OM;
                    end
                end
                S_SHA_OM:
                begin
                    if (srsp.done)
                    begin
                        state_reg <= S_TRUNC;
                    end
                end
                S_TRUNC:
                begin
                    code_reg <= {dbyte[5'(off)][6:0], dbyte[5'(off) + 5'd1],
                                 dbyte[5'(off) + 5'd2], dbyte[5'(off) + 5'd3]};
                    rsp.valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rsp.ready)
                    begin
                        rsp.valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.data = {code_reg, step_reg, seq_reg};
endmodule

### bench/otp_result_checker.sv
`timescale 1ns / 1ps
// checker for the time step one-time code generator: follows config writes,
// predicts each code with its own hmac-sha256 and compares results in order
// depends on totp_pkg and totp_stream_if
module otp_result_checker
    import totp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    totp_stream_if req,
    totp_stream_if rsp,
    output int failures
);

    typedef struct packed {
        logic [30:0] code;
        logic signed [31:0] step;
        logic [31:0] seq;
    } otp_t;

    logic [63:0] key_hi, key_lo;
    logic [15:0] sender_addr, step_len;
    logic [30:0] t_start;
    logic [31:0] prev_step, seq_count;
    otp_t expected_codes[$];
    int mismatches;

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic digest_t compress(input digest_t chain, input block_t blk);
        word_t w[64];
        word_t v[8];
        word_t t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = blk[511-32*i -: 32];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = chain[255-32*i -: 32];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(i[5:0]) + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[255-32*i -: 32] = chain[255-32*i -: 32] + v[i];
        return chain;
    endfunction

    // both hmac passes fit in two blocks
    function automatic digest_t hash_two_blocks(input logic [7:0] msg[128], input int len);
        block_t b0, b1;
        logic [63:0] bits;
        bits = 64'(len) * 8;
        msg[len] = 8'h80;
        for (int i = len + 1; i < 120; i++)
            msg[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg[127-i] = bits[8*i +: 8];
        for (int i = 0; i < 64; i++)
        begin
            b0[511-8*i -: 8] = msg[i];
            b1[511-8*i -: 8] = msg[64+i];
        end
        return compress(compress(SHA_IV, b0), b1);
    endfunction

    function automatic logic [30:0] predict_code(input logic [31:0] step, input logic [31:0] seq);
        logic [7:0] key_bytes[64];
        logic [7:0] buffer[128];
        logic [7:0] d[32];
        digest_t inner, outer;
        int off;
        for (int i = 0; i < 64; i++)
            key_bytes[i] = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            key_bytes[i] = key_hi[63-8*i -: 8];
            key_bytes[8+i] = key_lo[63-8*i -: 8];
        end
        for (int i = 0; i < 64; i++)
            buffer[i] = key_bytes[i] ^ IPAD;
        for (int i = 0; i < 4; i++)
        begin
            buffer[64+i] = step[8*i +: 8];
            buffer[68+i] = seq[8*i +: 8];
        end
        buffer[72] = sender_addr[7:0];
        buffer[73] = sender_addr[15:8];
        inner = hash_two_blocks(buffer, 74);
        for (int i = 0; i < 64; i++)
            buffer[i] = key_bytes[i] ^ OPAD;
        for (int i = 0; i < 32; i++)
            buffer[64+i] = inner[255-8*i -: 8];
        outer = hash_two_blocks(buffer, 96);
        for (int i = 0; i < 32; i++)
            d[i] = outer[255-8*i -: 8];
        off = int'(d[31][3:0]);
        return {d[off][6:0], d[off+1], d[off+2], d[off+3]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] diff, divisor;
        logic [31:0] step;
        otp_t exp_item, got;
        if (!rst_n)
        begin
            key_hi = KEY_HIGH_RESET;
            key_lo = KEY_LOW_RESET;
            sender_addr = SOURCE_ADDRESS_RESET;
            step_len = STEP_SECONDS_RESET;
            t_start = START_TIME_RESET;
            prev_step = '0;
            seq_count = '0;
            expected_codes.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_HIGH: key_hi = cfg_data;
                    CFG_KEY_LOW: key_lo = cfg_data;
                    CFG_SOURCE_ADDRESS: sender_addr = cfg_data[15:0];
                    CFG_STEP_SECONDS: step_len = cfg_data[15:0];
                    CFG_START_TIME: t_start = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                diff = 64'(signed'(32'(req.data) - {1'b0, t_start}));
                divisor = (step_len == 0) ? 64'sd1 : 64'(step_len);
                step = 32'(diff / divisor);
                if (step != prev_step)
                begin
                    prev_step = step;
                    seq_count = '0;
                end
                else
                    seq_count = seq_count + 1;
                exp_item.code = predict_code(step, seq_count);
                exp_item.step = step;
                exp_item.seq = seq_count;
                expected_codes.push_back(exp_item);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (expected_codes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result code=%h step=%0d seq=%0d",
                                 got.code, got.step, got.seq);
                end
                else
                begin
                    exp_item = expected_codes.pop_front();
                    if (got != exp_item)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: code %h/%h step %0d/%0d seq %0d/%0d (exp/got)",
                                     exp_item.code, got.code, exp_item.step, got.step,
                                     exp_item.seq, got.seq);
                    end
                end
            end
        end
    end

    assign failures = mismatches + expected_codes.size();

endmodule

### bench/tb_time_step_otp_generator.sv
`timescale 1ns / 1ps
// top of the bench for the time step one-time code generator: clock, reset,
// config writes, request stimulus with random gaps and the verdict
// depends on totp_pkg, totp_stream_if, otp_result_checker and the block
module tb_time_step_otp_generator;
    import totp_pkg::*;

    // indexes past the register list, expected to be ignored
    localparam logic [CfgIndexWidth-1:0] CFG_UNUSED_FIRST = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_UNUSED_LAST = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = CFG_KEY_HIGH;
    logic [CfgDataWidth-1:0] cfg_data = '0;
    int failures;
    int sent = 0;
    int done_count = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    logic [31:0] last_now = 32'd0;
    logic [30:0] cur_start = START_TIME_RESET;

    totp_stream_if #(.payload_t(logic [31:0])) req ();
    totp_stream_if #(.payload_t(logic [94:0])) rsp ();

    initial
    begin
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
    end

    time_step_otp_generator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
    );

    otp_result_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req), .rsp(rsp), .failures(failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(input int longest);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, longest);
    endfunction

    // result side stalls
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            n = pick_gap(200);
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            done_count <= done_count + 1;
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000)
        begin
            $display("watchdog: no request or result moved for 20000 cycles");
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_START_TIME)
            cur_start = val[30:0];
    endtask

    task automatic send(input logic [31:0] now);
        int n;
        n = pick_gap(100);
        if (n > 0)
        begin
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= now;
        do @(posedge clk); while (!req.ready);
        sent++;
        last_now = now;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (done_count != sent)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return last_now + $urandom_range(0, 2);
        if (r < 80)
            return {1'b0, cur_start} + 32'($urandom_range(0, 400)) - 32'd200;
        return $urandom;
    endfunction

    task automatic random_config();
        int r;
        r = $urandom_range(0, 3);
        write_reg(CFG_KEY_HIGH, r == 0 ? 64'd0 : r == 1 ? '1 : {$urandom, $urandom});
        write_reg(CFG_KEY_LOW, r == 0 ? 64'd0 : r == 1 ? '1 : {$urandom, $urandom});
        write_reg(CFG_SOURCE_ADDRESS, r == 0 ? 64'd0 : r == 1 ? 64'hffff : 64'($urandom));
        write_reg(CFG_STEP_SECONDS, r == 0 ? 64'd1 : r == 1 ? 64'hffff :
                  64'($urandom_range(0, 20)));
        write_reg(CFG_START_TIME, r == 0 ? 64'd0 : r == 1 ? 64'h7fffffff :
                  64'($urandom));
    endtask

    initial
    begin
        logic [31:0] s;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first request lands on step zero, so its sequence is one
        s = {1'b0, START_TIME_RESET};
        send(s); send(s + 1); send(s + 3); send(s - 1); send(s - 4);
        send(32'h0); send(32'hffffffff); send(32'h80000000); send(32'h7fffffff);
        drain();
        // zero step length acts as one
        write_reg(CFG_STEP_SECONDS, 64'd0);
        send(s + 5); send(s + 5); send(s - 7);
        drain();
        write_reg(CFG_STEP_SECONDS, 64'hffff);
        write_reg(CFG_UNUSED_FIRST, 64'hdeadbeef);
        write_reg(CFG_UNUSED_LAST, '1);
        send(s + 65534); send(s + 65535); send(s - 65536);
        drain();
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LOW, '0);
        write_reg(CFG_SOURCE_ADDRESS, 64'hffff);
        write_reg(CFG_START_TIME, 64'h7fffffff);
        send(32'h0); send(32'hffffffff); send(32'h7fffffff);
        drain();
        write_reg(CFG_START_TIME, 64'd0);
        write_reg(CFG_SOURCE_ADDRESS, 64'd0);
        send(32'h0); send(32'hffffffff); send(32'h80000000);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            random_config();
            quiet = (phase == 2);
            for (int i = 0; i < 270; i++)
            begin
                send(random_now());
                if (i == 135)
                    drain();
            end
            drain();
        end
        quiet = 0;
        repeat (50) @(posedge clk);

        $display("%0d codes requested and %0d returned over directed corner times", sent,
                 done_count);
        $display("and six random key, address, step and start settings");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### time_step_otp_generator.f
rtl/core/totp_pkg.sv
rtl/core/totp_stream_if.sv
rtl/core/totp_divider.sv
rtl/core/totp_sha_core.sv
rtl/core/time_step_otp_generator.sv
bench/otp_result_checker.sv
bench/tb_time_step_otp_generator.sv
